>>> src/two_link_polar_leg_kinematics_defines.svh
// Assertion helpers for the leg kinematics block
`ifndef TWO_LINK_POLAR_LEG_KINEMATICS_DEFINES_SVH
`define TWO_LINK_POLAR_LEG_KINEMATICS_DEFINES_SVH

// same-cycle implication
`define TLPK_AST_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLPK_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tlpk_pkg.sv
package tlpk_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ROT_W  = 34;
    localparam int VEC_W  = 36;
    localparam int BXW    = 33;
    localparam int R28W   = 34;
    localparam int DEN_W  = 36;
    localparam int NUM_W  = 50;
    localparam int QB     = 40;

    localparam logic [30:0]   GAIN_Q30  = 31'd652032874;
    localparam logic [QB-1:0] RATIO_LIM = 40'h40_0000_0000;
    localparam logic [15:0]   LINK_RST  = 16'd3277;

    // register index, taken from paddr[2]
    localparam logic REG_UPPER = 1'b0;
    localparam logic REG_LOWER = 1'b1;

    function automatic logic [31:0] atan_at(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic [23:0] sat24(input logic signed [63:0] v);
        logic [23:0] r;
        if (v > 64'sd8388607) begin
            r = 24'h7FFFFF;
        end else if (v < -64'sd8388608) begin
            r = 24'h800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

>>> src/tlpk_rot_cell.sv
module tlpk_rot_cell #(
    parameter int IDX = 0
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [tlpk_pkg::ROT_W-1:0] i_x,
    input  logic signed [tlpk_pkg::ROT_W-1:0] i_y,
    input  logic signed [tlpk_pkg::ROT_W-1:0] i_z,
    output logic signed [tlpk_pkg::ROT_W-1:0] o_x,
    output logic signed [tlpk_pkg::ROT_W-1:0] o_y,
    output logic signed [tlpk_pkg::ROT_W-1:0] o_z
);
    import tlpk_pkg::*;

    logic signed [ROT_W-1:0] w_xs, w_ys, w_at;
    logic signed [ROT_W-1:0] r_x, r_y, r_z;

    assign w_xs = i_x >>> IDX;
    assign w_ys = i_y >>> IDX;
    assign w_at = $signed({{(ROT_W-32){1'b0}}, atan_at(IDX)});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_z[ROT_W-1]) begin
                r_x <= i_x - w_ys;
                r_y <= i_y + w_xs;
                r_z <= i_z - w_at;
            end else begin
                r_x <= i_x + w_ys;
                r_y <= i_y - w_xs;
                r_z <= i_z + w_at;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

>>> src/tlpk_vec_cell.sv
module tlpk_vec_cell #(
    parameter int IDX = 0
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [tlpk_pkg::VEC_W-1:0] i_x,
    input  logic signed [tlpk_pkg::VEC_W-1:0] i_y,
    input  logic        [31:0]                i_z,
    output logic signed [tlpk_pkg::VEC_W-1:0] o_x,
    output logic signed [tlpk_pkg::VEC_W-1:0] o_y,
    output logic        [31:0]                o_z
);
    import tlpk_pkg::*;

    logic signed [VEC_W-1:0] w_xs, w_ys;
    logic signed [VEC_W-1:0] r_x, r_y;
    logic        [31:0]      r_z;

    assign w_xs = i_x >>> IDX;
    assign w_ys = i_y >>> IDX;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_y[VEC_W-1]) begin
                r_x <= i_x + w_ys;
                r_y <= i_y - w_xs;
                r_z <= i_z + atan_at(IDX);
            end else begin
                r_x <= i_x - w_ys;
                r_y <= i_y + w_xs;
                r_z <= i_z - atan_at(IDX);
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

>>> src/tlpk_div_cell.sv
module tlpk_div_cell (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [tlpk_pkg::DEN_W-1:0] i_rem,
    input  logic [tlpk_pkg::QB-1:0]    i_bits,
    input  logic [tlpk_pkg::DEN_W-1:0] i_den,
    input  logic [tlpk_pkg::QB-1:0]    i_q,
    output logic [tlpk_pkg::DEN_W-1:0] o_rem,
    output logic [tlpk_pkg::QB-1:0]    o_bits,
    output logic [tlpk_pkg::DEN_W-1:0] o_den,
    output logic [tlpk_pkg::QB-1:0]    o_q
);
    import tlpk_pkg::*;

    logic [DEN_W:0]   w_t, w_d;
    logic             w_ge;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [QB-1:0]    r_bits, r_q;

    assign w_t  = {i_rem, i_bits[QB-1]};
    assign w_ge = w_t >= {1'b0, i_den};
    assign w_d  = w_t - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= w_ge ? w_d[DEN_W-1:0] : w_t[DEN_W-1:0];
            r_bits <= {i_bits[QB-2:0], 1'b0};
            r_den  <= i_den;
            r_q    <= {i_q[QB-2:0], w_ge};
        end
    end

    assign o_rem  = r_rem;
    assign o_bits = r_bits;
    assign o_den  = r_den;
    assign o_q    = r_q;

endmodule

>>> src/two_link_polar_leg_kinematics.sv
// Channel   Dir  Handshake                Payload
// s_*       in   s_tvalid / s_tready      joint angles, rates, efforts
// m_*       out  m_tvalid / m_tready      leg length, angle, polar rates, torques; tuser singular
// apb       in   psel / penable / pready  link lengths, word index paddr[2]
//
// One transfer per cycle in and out while the output is not held; the data path runs
// through the rotation and vectoring cell rows and the 40-cell restoring divider rows.
// Reset is synchronous; it clears valid bits and loads both link lengths with 3277.
// A held result freezes the whole row only when the last stage also holds an item.
`include "two_link_polar_leg_kinematics_defines.svh"

module two_link_polar_leg_kinematics #(
    parameter int CORDIC_STAGES = tlpk_pkg::CORDIC_STAGES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // hip_angle, knee_angle, hip_rate, knee_rate, radial_effort, angular_effort
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // leg_length, leg_angle, length_rate, angle_rate, hip_torque, knee_torque, zero pad
    output logic [135:0] m_tdata,
    // singular
    output logic         m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import tlpk_pkg::*;

    localparam int N = CORDIC_STAGES;

    typedef struct packed {
        logic signed [15:0] q0;
        logic signed [23:0] w0;
        logic signed [23:0] w1;
        logic signed [23:0] fr;
        logic signed [23:0] ft;
    } t_joint;

    typedef struct packed {
        t_joint j;
        logic   flip;
    } t_side_a;

    typedef struct packed {
        t_joint                j;
        logic signed [BXW-1:0] by;
        logic signed [BXW-1:0] wv;
    } t_side_b;

    typedef struct packed {
        logic [15:0]        theta;
        logic [16:0]        r14;
        logic               sing;
        logic signed [23:0] w0;
        logic signed [23:0] w1;
        logic signed [23:0] fr;
        logic signed [23:0] ft;
    } t_side_c;

    typedef struct packed {
        t_side_c c;
        logic    over_a;
        logic    sign_a;
        logic    over_b;
        logic    sign_b;
    } t_side_d;

    // configuration
    logic [15:0] r_l1, r_l2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1 <= LINK_RST;
            r_l2 <= LINK_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_UPPER) begin
                r_l1 <= pwdata[15:0];
            end else begin
                r_l2 <= pwdata[15:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = {16'h0, (paddr[2] == REG_LOWER) ? r_l2 : r_l1};

    // flow control
    logic w_en, w_acc, r_f1_v, r_ov;

    assign w_en     = !(r_ov && !m_tready && r_f1_v);
    assign s_tready = w_en;
    assign w_acc    = s_tvalid && w_en;

    // input unpack and rotation prep
    t_joint      w_in_j;
    logic [31:0] w_u, w_uf;
    logic        w_flip;

    assign w_in_j.q0 = s_tdata[15:0];
    assign w_in_j.w0 = s_tdata[55:32];
    assign w_in_j.w1 = s_tdata[79:56];
    assign w_in_j.fr = s_tdata[103:80];
    assign w_in_j.ft = s_tdata[127:104];
    assign w_u       = {s_tdata[31:16], 16'h0};
    assign w_flip    = w_u[31] ^ w_u[30];
    assign w_uf      = {w_u[31] ^ w_flip, w_u[30:0]};

    logic signed [ROT_W-1:0] w_rx [N+1];
    logic signed [ROT_W-1:0] w_ry [N+1];
    logic signed [ROT_W-1:0] w_rz [N+1];
    logic                    w_rot_v [N+1];
    t_side_a                 w_rot_s [N+1];

    assign w_rx[0]         = $signed({{(ROT_W-31){1'b0}}, GAIN_Q30});
    assign w_ry[0]         = '0;
    assign w_rz[0]         = $signed({{(ROT_W-32){w_uf[31]}}, w_uf});
    assign w_rot_v[0]      = w_acc;
    assign w_rot_s[0].j    = w_in_j;
    assign w_rot_s[0].flip = w_flip;

    for (genvar g = 0; g < N; g++) begin : g_rot
        logic    r_v;
        t_side_a r_s;

        tlpk_rot_cell #(.IDX(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (w_rx[g]),
            .i_y   (w_ry[g]),
            .i_z   (w_rz[g]),
            .o_x   (w_rx[g+1]),
            .o_y   (w_ry[g+1]),
            .o_z   (w_rz[g+1])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (w_en) begin
                r_v <= w_rot_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_s <= w_rot_s[g];
            end
        end

        assign w_rot_v[g+1] = r_v;
        assign w_rot_s[g+1] = r_s;
    end

    // foot vector in knee frame
    logic signed [ROT_W-1:0] w_c, w_s;
    logic signed [50:0]      w_l2c, w_l2s, w_l1c, w_l2c_s, w_l2s_s, w_l1c_s, w_bx, w_wv;
    logic signed [BXW-1:0]   r_p_bx, r_p_by, r_p_wv;
    t_joint                  r_p_j;
    logic                    r_p_v;

    assign w_c     = w_rot_s[N].flip ? -w_rx[N] : w_rx[N];
    assign w_s     = w_rot_s[N].flip ? -w_ry[N] : w_ry[N];
    assign w_l2c   = $signed({1'b0, r_l2}) * w_c;
    assign w_l2s   = $signed({1'b0, r_l2}) * w_s;
    assign w_l1c   = $signed({1'b0, r_l1}) * w_c;
    assign w_l2c_s = w_l2c >>> 16;
    assign w_l2s_s = w_l2s >>> 16;
    assign w_l1c_s = w_l1c >>> 16;
    assign w_bx    = $signed({21'h0, r_l1, 14'h0}) + w_l2c_s;
    assign w_wv    = $signed({21'h0, r_l2, 14'h0}) + w_l1c_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (w_en) begin
            r_p_v <= w_rot_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_bx <= w_bx[BXW-1:0];
            r_p_by <= w_l2s_s[BXW-1:0];
            r_p_wv <= w_wv[BXW-1:0];
            r_p_j  <= w_rot_s[N].j;
        end
    end

    // vectoring row
    logic signed [VEC_W-1:0] w_vx [N+1];
    logic signed [VEC_W-1:0] w_vy [N+1];
    logic        [31:0]      w_vz [N+1];
    logic                    w_vec_v [N+1];
    t_side_b                 w_vec_s [N+1];
    logic signed [VEC_W-1:0] w_bx_e, w_by_e;

    assign w_bx_e        = $signed({{(VEC_W-BXW){r_p_bx[BXW-1]}}, r_p_bx});
    assign w_by_e        = $signed({{(VEC_W-BXW){r_p_by[BXW-1]}}, r_p_by});
    assign w_vx[0]       = r_p_bx[BXW-1] ? -w_bx_e : w_bx_e;
    assign w_vy[0]       = r_p_bx[BXW-1] ? -w_by_e : w_by_e;
    assign w_vz[0]       = r_p_bx[BXW-1] ? 32'h8000_0000 : 32'h0;
    assign w_vec_v[0]    = r_p_v;
    assign w_vec_s[0].j  = r_p_j;
    assign w_vec_s[0].by = r_p_by;
    assign w_vec_s[0].wv = r_p_wv;

    for (genvar g = 0; g < N; g++) begin : g_vec
        logic    r_v;
        t_side_b r_s;

        tlpk_vec_cell #(.IDX(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (w_vx[g]),
            .i_y   (w_vy[g]),
            .i_z   (w_vz[g]),
            .o_x   (w_vx[g+1]),
            .o_y   (w_vy[g+1]),
            .o_z   (w_vz[g+1])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (w_en) begin
                r_v <= w_vec_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_s <= w_vec_s[g];
            end
        end

        assign w_vec_v[g+1] = r_v;
        assign w_vec_s[g+1] = r_s;
    end

    // gain correction
    logic signed [66:0] w_mp;
    logic [R28W-1:0]    r_m1_r28;
    logic [31:0]        r_m1_phi;
    t_side_b            r_m1_s;
    logic               r_m1_v;

    assign w_mp = w_vx[N] * $signed({1'b0, GAIN_Q30});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
        end else if (w_en) begin
            r_m1_v <= w_vec_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_r28 <= w_mp[30+R28W-1:30];
            r_m1_phi <= w_vz[N];
            r_m1_s   <= w_vec_s[N];
        end
    end

    // r^2, numerators, leg length and angle
    logic [2*R28W-1:0]       w_sq;
    logic [19:0]             w_hi;
    logic                    w_sing;
    logic [31:0]             w_th;
    logic signed [NUM_W-1:0] w_na, w_nb;
    logic [R28W-1:0]         r_m2_r28;
    logic [DEN_W-1:0]        r_m2_r2;
    logic signed [NUM_W-1:0] r_m2_na, r_m2_nb;
    t_side_c                 r_m2_c;
    logic                    r_m2_v;

    assign w_sq   = r_m1_r28 * r_m1_r28;
    assign w_hi   = r_m1_r28[R28W-1:14];
    assign w_sing = (w_hi == 20'h0);
    assign w_th   = {r_m1_s.j.q0, 16'h0} + (w_sing ? 32'h0 : r_m1_phi) + 32'h8000;
    assign w_na   = $signed({1'b0, r_l1}) * r_m1_s.by;
    assign w_nb   = $signed({1'b0, r_l2}) * r_m1_s.wv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_v <= 1'b0;
        end else if (w_en) begin
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2_r28     <= r_m1_r28;
            r_m2_r2      <= w_sq[28+DEN_W-1:28];
            r_m2_na      <= w_na;
            r_m2_nb      <= w_nb;
            r_m2_c.theta <= w_th[31:16];
            r_m2_c.r14   <= (|w_hi[19:17]) ? 17'h1FFFF : w_hi[16:0];
            r_m2_c.sing  <= w_sing;
            r_m2_c.w0    <= r_m1_s.j.w0;
            r_m2_c.w1    <= r_m1_s.j.w1;
            r_m2_c.fr    <= r_m1_s.j.fr;
            r_m2_c.ft    <= r_m1_s.j.ft;
        end
    end

    // divider prep: quotients of 2^40 and above saturate at once
    logic [NUM_W-1:0] w_ma, w_mb;
    logic [DEN_W-1:0] w_ha, w_hb, w_da;

    assign w_ma = r_m2_na[NUM_W-1] ? 50'(-r_m2_na) : 50'(r_m2_na);
    assign w_mb = r_m2_nb[NUM_W-1] ? 50'(-r_m2_nb) : 50'(r_m2_nb);
    assign w_ha = {{(DEN_W-NUM_W+24){1'b0}}, w_ma[NUM_W-1:24]};
    assign w_hb = {{(DEN_W-NUM_W+24){1'b0}}, w_mb[NUM_W-1:24]};
    assign w_da = {{(DEN_W-R28W){1'b0}}, r_m2_r28};

    logic [DEN_W-1:0] w_a_rem [QB+1];
    logic [QB-1:0]    w_a_bit [QB+1];
    logic [DEN_W-1:0] w_a_den [QB+1];
    logic [QB-1:0]    w_a_q   [QB+1];
    logic [DEN_W-1:0] w_b_rem [QB+1];
    logic [QB-1:0]    w_b_bit [QB+1];
    logic [DEN_W-1:0] w_b_den [QB+1];
    logic [QB-1:0]    w_b_q   [QB+1];
    logic             w_div_v [QB+1];
    t_side_d          w_div_s [QB+1];
    logic [DEN_W-1:0] r_dp_ra, r_dp_da, r_dp_rb, r_dp_db;
    logic [QB-1:0]    r_dp_ba, r_dp_bb;
    t_side_d          r_dp_s;
    logic             r_dp_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dp_v <= 1'b0;
        end else if (w_en) begin
            r_dp_v <= r_m2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dp_ra       <= w_ha;
            r_dp_da       <= w_da;
            r_dp_ba       <= {w_ma[23:0], 16'h0};
            r_dp_rb       <= w_hb;
            r_dp_db       <= r_m2_r2;
            r_dp_bb       <= {w_mb[23:0], 16'h0};
            r_dp_s.c      <= r_m2_c;
            r_dp_s.over_a <= w_ha >= w_da;
            r_dp_s.sign_a <= r_m2_na[NUM_W-1];
            r_dp_s.over_b <= w_hb >= r_m2_r2;
            r_dp_s.sign_b <= r_m2_nb[NUM_W-1];
        end
    end

    assign w_a_rem[0] = r_dp_ra;
    assign w_a_bit[0] = r_dp_ba;
    assign w_a_den[0] = r_dp_da;
    assign w_a_q[0]   = '0;
    assign w_b_rem[0] = r_dp_rb;
    assign w_b_bit[0] = r_dp_bb;
    assign w_b_den[0] = r_dp_db;
    assign w_b_q[0]   = '0;
    assign w_div_v[0] = r_dp_v;
    assign w_div_s[0] = r_dp_s;

    for (genvar g = 0; g < QB; g++) begin : g_div
        logic    r_v;
        t_side_d r_s;

        tlpk_div_cell u_cell_a (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_a_rem[g]),
            .i_bits (w_a_bit[g]),
            .i_den  (w_a_den[g]),
            .i_q    (w_a_q[g]),
            .o_rem  (w_a_rem[g+1]),
            .o_bits (w_a_bit[g+1]),
            .o_den  (w_a_den[g+1]),
            .o_q    (w_a_q[g+1])
        );

        tlpk_div_cell u_cell_b (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_b_rem[g]),
            .i_bits (w_b_bit[g]),
            .i_den  (w_b_den[g]),
            .i_q    (w_b_q[g]),
            .o_rem  (w_b_rem[g+1]),
            .o_bits (w_b_bit[g+1]),
            .o_den  (w_b_den[g+1]),
            .o_q    (w_b_q[g+1])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (w_en) begin
                r_v <= w_div_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_s <= w_div_s[g];
            end
        end

        assign w_div_v[g+1] = r_v;
        assign w_div_s[g+1] = r_s;
    end

    // ratio clamp and sign
    logic [QB-1:0]        w_qa, w_qb;
    logic signed [QB-1:0] w_a, w_b, r_q_a, r_q_b;
    t_side_c              r_q_c;
    logic                 r_q_v;

    assign w_qa = (w_div_s[QB].over_a || w_a_q[QB] > RATIO_LIM) ? RATIO_LIM : w_a_q[QB];
    assign w_qb = (w_div_s[QB].over_b || w_b_q[QB] > RATIO_LIM) ? RATIO_LIM : w_b_q[QB];
    assign w_a  = w_div_s[QB].c.sing ? '0 :
                  (w_div_s[QB].sign_a ? $signed(-w_qa) : $signed(w_qa));
    assign w_b  = w_div_s[QB].c.sing ? '0 :
                  (w_div_s[QB].sign_b ? $signed(-w_qb) : $signed(w_qb));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_v <= 1'b0;
        end else if (w_en) begin
            r_q_v <= w_div_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q_a <= w_a;
            r_q_b <= w_b;
            r_q_c <= w_div_s[QB].c;
        end
    end

    // Jacobian products
    logic signed [63:0] w_p_aw, w_p_bw, w_p_bf, w_p_ar;
    logic signed [63:0] r_f1_aw, r_f1_bw, r_f1_bf, r_f1_ar;
    t_side_c            r_f1_c;

    assign w_p_aw = r_q_a * r_q_c.w1;
    assign w_p_bw = r_q_b * r_q_c.w1;
    assign w_p_bf = r_q_b * r_q_c.ft;
    assign w_p_ar = r_q_a * r_q_c.fr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (w_en) begin
            r_f1_v <= r_q_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_aw <= w_p_aw;
            r_f1_bw <= w_p_bw;
            r_f1_bf <= w_p_bf;
            r_f1_ar <= w_p_ar;
            r_f1_c  <= r_q_c;
        end
    end

    // output register
    logic signed [63:0] w_aw_s, w_bw_s, w_kt_s, w_lr, w_ar;
    logic [23:0]        w_lr24, w_ar24, w_kt24;
    logic [135:0]       r_o_data;
    logic               r_o_sing;

    assign w_aw_s = r_f1_aw >>> 30;
    assign w_bw_s = r_f1_bw >>> 30;
    assign w_kt_s = (r_f1_bf - r_f1_ar) >>> 30;
    assign w_lr   = -w_aw_s;
    assign w_ar   = $signed({{40{r_f1_c.w0[23]}}, r_f1_c.w0}) + w_bw_s;
    assign w_lr24 = sat24(w_lr);
    assign w_ar24 = sat24(w_ar);
    assign w_kt24 = sat24(w_kt_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (!r_ov || m_tready) begin
            r_ov <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || m_tready) begin
            r_o_data <= {7'h0, w_kt24, r_f1_c.ft, w_ar24, w_lr24, r_f1_c.theta, r_f1_c.r14};
            r_o_sing <= r_f1_c.sing;
        end
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = r_o_data;
    assign m_tuser  = r_o_sing;

    `TLPK_AST_NOW(a_sing_zero, m_tvalid && m_tuser, (m_tdata[16:0] == 17'h0) && (m_tdata[56:33] == 24'h0) && (m_tdata[128:105] == 24'h0), "singular result with nonzero terms")
    `TLPK_AST_NOW(a_len_nonzero, m_tvalid && !m_tuser, m_tdata[16:0] != 17'h0, "zero length without singular flag")
    `TLPK_AST_NOW(a_freeze, r_ov && !m_tready && r_f1_v, !s_tready, "input taken while row is frozen")

endmodule

>>> tb/sv/two_link_polar_leg_kinematics_test.sv
`timescale 1ns / 100ps

module two_link_polar_leg_kinematics_test;
    import tlpk_pkg::*;

    localparam int LATENCY    = 2 * CORDIC_STAGES_DEF + 47;
    localparam int CYCLE_CAP  = 400000;
    localparam int MAP_STAGES = CORDIC_STAGES_DEF;

    typedef struct {
        logic [15:0] hip_angle;
        logic [15:0] knee_angle;
        logic [23:0] hip_rate;
        logic [23:0] knee_rate;
        logic [23:0] radial_effort;
        logic [23:0] angular_effort;
    } t_joint;

    typedef struct {
        logic [16:0] leg_length;
        logic [15:0] leg_angle;
        logic [23:0] length_rate;
        logic [23:0] angle_rate;
        logic [23:0] hip_torque;
        logic [23:0] knee_torque;
        logic        singular;
    } t_pose;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic         m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    logic [15:0] link_upper;
    logic [15:0] link_lower;
    t_pose       pose_fifo[$];
    int          fail_count;
    int          cycle_count;
    int          hold_cycles;
    bit          calm;

    longint atan_q32[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    two_link_polar_leg_kinematics uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [23:0] sat_q12(longint v);
        longint c;
        c = clip(v, -64'sd8388608, 64'sd8388607);
        return c[23:0];
    endfunction

    function automatic longint ratio_q30(longint num, longint den);
        longint lim;
        lim = 64'sd1 <<< 38;
        return clip((num * 65536) / den, -lim, lim);
    endfunction

    function automatic t_pose leg_predict(t_joint j);
        t_pose       p;
        int unsigned u, phi, theta;
        bit          flip;
        longint      x, y, z, xs, ys, c, s, bx, by, r28, r14, a, b, w, r2;
        longint      l1, l2, q0, w0, w1, fr, ft;
        l1 = link_upper;
        l2 = link_lower;
        q0 = $signed(j.hip_angle);
        w0 = $signed(j.hip_rate);
        w1 = $signed(j.knee_rate);
        fr = $signed(j.radial_effort);
        ft = $signed(j.angular_effort);

        // knee sin/cos, folded to the right half plane
        u = {j.knee_angle, 16'h0000};
        flip = (u[31:30] == 2'd1) || (u[31:30] == 2'd2);
        if (flip) u = u + 32'h80000000;
        z = longint'(signed'(u));
        x = longint'(GAIN_Q30);
        y = 0;
        for (int i = 0; i < MAP_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - atan_q32[i];
            end else begin
                x = x + ys; y = y - xs; z = z + atan_q32[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;

        bx = l1 * 16384 + ((l2 * c) >>> 16);
        by = (l2 * s) >>> 16;

        // foot vector to polar
        x = bx;
        y = by;
        phi = 0;
        if (x < 0) begin
            x = -x; y = -y; phi = 32'h80000000;
        end
        for (int i = 0; i < MAP_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; phi = phi + int'(atan_q32[i]);
            end else begin
                x = x - ys; y = y + xs; phi = phi - int'(atan_q32[i]);
            end
        end
        r28 = (x * longint'(GAIN_Q30)) >>> 30;
        r14 = clip(r28 >>> 14, 0, 131071);
        a = 0;
        b = 0;
        if (r14 != 0) begin
            w  = l2 * 16384 + ((l1 * c) >>> 16);
            r2 = (r28 * r28) >>> 28;
            a  = ratio_q30(l1 * by, r28);
            b  = ratio_q30(l2 * w, r2);
        end else begin
            phi = 0;
        end
        theta = ({j.hip_angle, 16'h0000} + phi + 32'h8000) >> 16;

        p.leg_length  = r14[16:0];
        p.leg_angle   = theta[15:0];
        p.length_rate = sat_q12(-((a * w1) >>> 30));
        p.angle_rate  = sat_q12(w0 + ((b * w1) >>> 30));
        p.hip_torque  = j.angular_effort;
        p.knee_torque = sat_q12((b * ft - a * fr) >>> 30);
        p.singular    = (r14 == 0);
        return p;
    endfunction

    // receiver: random stalls, plus long hold-offs on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 3) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pose want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pose_fifo.size() == 0) begin
                $error("result transfer with no pose expected");
                fail_count++;
            end else begin
                want = pose_fifo.pop_front();
                check_field("leg_length", 32'(want.leg_length), 32'(m_tdata[16:0]));
                check_field("leg_angle", 32'(want.leg_angle), 32'(m_tdata[32:17]));
                check_field("length_rate", 32'(want.length_rate), 32'(m_tdata[56:33]));
                check_field("angle_rate", 32'(want.angle_rate), 32'(m_tdata[80:57]));
                check_field("hip_torque", 32'(want.hip_torque), 32'(m_tdata[104:81]));
                check_field("knee_torque", 32'(want.knee_torque), 32'(m_tdata[128:105]));
                check_field("singular", 32'(want.singular), 32'(m_tuser));
            end
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_CAP) begin
                $display("** two_link_polar_leg_kinematics: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_joint(t_joint j);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {j.angular_effort, j.radial_effort, j.knee_rate, j.hip_rate,
                     j.knee_angle, j.hip_angle};
        do @(posedge i_clk); while (!s_tready);
        pose_fifo.push_back(leg_predict(j));
        @(negedge i_clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pose_fifo.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);
    endtask

    task automatic write_link(logic reg_sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_UPPER) link_upper = value[15:0];
        else link_lower = value[15:0];
        @(negedge i_clk);
    endtask

    function automatic t_joint random_joint();
        t_joint j;
        j.hip_angle      = 16'($urandom());
        j.knee_angle     = ($urandom_range(0, 7) == 0)
                           ? 16'(16'h8000 + $urandom_range(0, 6) - 3)
                           : 16'($urandom());
        j.hip_rate       = 24'($urandom());
        j.knee_rate      = 24'($urandom());
        j.radial_effort  = 24'($urandom());
        j.angular_effort = 24'($urandom());
        if ($urandom_range(0, 3) == 0) begin
            j.hip_rate      = $signed(j.hip_rate) >>> 10;
            j.knee_rate     = $signed(j.knee_rate) >>> 10;
            j.radial_effort = $signed(j.radial_effort) >>> 10;
        end
        return j;
    endfunction

    function automatic t_joint make_joint(logic [15:0] q0, logic [15:0] q1, logic [23:0] w0,
                                          logic [23:0] w1, logic [23:0] fr, logic [23:0] ft);
        t_joint j;
        j.hip_angle = q0; j.knee_angle = q1; j.hip_rate = w0;
        j.knee_rate = w1; j.radial_effort = fr; j.angular_effort = ft;
        return j;
    endfunction

    task automatic test_directed;
        logic [15:0] knees[8] = '{16'h0000, 16'h4000, 16'h7FFF, 16'h8000,
                                  16'hC000, 16'h0001, 16'hFFFF, 16'h8001};
        foreach (knees[k]) begin
            send_joint(make_joint(16'h7FFF, knees[k], 24'h7FFFFF, 24'h7FFFFF,
                                  24'h800000, 24'h7FFFFF));
            send_joint(make_joint(16'h8000, knees[k], 24'h800000, 24'h800000,
                                  24'h7FFFFF, 24'h800000));
        end
        send_joint(make_joint(16'h0000, 16'h2000, 24'h001000, 24'h001000,
                              24'h001000, 24'h001000));
        send_joint(make_joint(16'hFFFF, 16'h1000, 24'h000000, 24'hFFFFFF,
                              24'h000001, 24'h000000));
        drain();
    endtask

    task automatic test_random_links(logic [31:0] up, logic [31:0] low, int count);
        write_link(REG_UPPER, up);
        write_link(REG_LOWER, low);
        repeat (count) send_joint(random_joint());
        drain();
    endtask

    task automatic test_output_backpressure;
        hold_cycles = 300;
        repeat (200) send_joint(random_joint());
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        hold_cycles = 0;
        calm = 1'b0;
        link_upper = LINK_RST;
        link_lower = LINK_RST;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_links(32'hFFFF_0000 | 32'd3277, 32'hABCD_0000 | 32'd3277, 150);
        test_random_links(32'd0, 32'd0, 60);
        test_random_links(32'hFFFF, 32'hFFFF, 200);
        test_random_links(32'd0, 32'hFFFF, 120);
        test_random_links(32'hFFFF, 32'd0, 120);
        test_random_links(32'd1, 32'd1, 80);
        test_random_links($urandom(), $urandom(), 200);
        test_output_backpressure();
        calm = 1'b1;
        test_random_links(32'd5000, 32'd4000, 150);

        if (fail_count == 0) begin
            $display("** two_link_polar_leg_kinematics: PASSED **");
        end else begin
            $display("** two_link_polar_leg_kinematics: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/tlpk_pkg.sv
src/tlpk_rot_cell.sv
src/tlpk_vec_cell.sv
src/tlpk_div_cell.sv
src/two_link_polar_leg_kinematics.sv
tb/sv/two_link_polar_leg_kinematics_test.sv
